// ===== sv/twtq_pkg.sv =====
package twtq_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ITEMS  = 32;
    localparam int ID_W   = 5;
    localparam int PTR_W  = ID_W + 1;
    localparam int TIME_W = 32;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [TIME_W-1:0] time_t;

    localparam ptr_t EMPTY     = {PTR_W{1'b1}};
    localparam ptr_t ITEMS_PTR = PTR_W'(ITEMS);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_TICK   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEFORE = 2'd1,
        ST_PAST   = 2'd2,
        ST_BEYOND = 2'd3
    } status_t;

    typedef struct packed {
        status_t status;
        logic    valid;
        id_t     id;
        logic    last;
    } res_t;

endpackage

// ===== sv/twtq_ram.sv =====
module twtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/twtq_ctrl.sv =====
module twtq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  twtq_pkg::op_t    in_op,
    input  twtq_pkg::id_t    in_id,
    input  twtq_pkg::time_t  in_expire,
    input  twtq_pkg::time_t  in_now,
    input  logic             out_free,
    output logic             res_push,
    output twtq_pkg::res_t   res
);
    import twtq_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD_WR1, S_ADD_WR2, S_RM_RD, S_RM_WR,
        S_TK_SLOT, S_TK_HEAD, S_TK_ITEM, S_TK_NEXT, S_TK_DONE, S_FINAL
    } state_t;

    state_t       state_reg;
    slot_t        clr_reg;
    time_t        start_reg;
    slot_t        base_reg;
    logic [ITEMS-1:0] linked_reg;
    id_t          id_reg;
    slot_t        sslot_reg;
    ptr_t         tail_reg;
    ptr_t         p_reg;
    ptr_t         n_reg;
    ptr_t         cur_reg;
    slot_t        idx_reg;
    slot_t        last_idx_reg;
    time_t        now_reg;
    status_t      status_reg;
    logic         pend_valid_reg;
    id_t          pend_id_reg;

    logic         slot_we;
    slot_t        slot_waddr, slot_raddr;
    logic [2*PTR_W-1:0] slot_wdata, slot_rdata;
    logic         next_we, prev_we, eslot_we;
    id_t          next_waddr, next_raddr, prev_waddr, eslot_waddr;
    ptr_t         next_wdata, next_rdata, prev_wdata, prev_rdata;
    slot_t        eslot_wdata, eslot_rdata;

    logic         st_unset;
    time_t        st_eff;
    slot_t        base_eff;
    time_t        add_d;
    slot_t        add_slot;
    time_t        tk_diff;
    slot_t        tk_last;
    slot_t        tk_slot;
    logic         accept;
    ptr_t         rd_head, rd_tail;
    ptr_t         id_ptr;

    assign st_unset = (start_reg == '0);
    assign st_eff   = st_unset ? in_now : start_reg;
    assign base_eff = st_unset ? '0 : base_reg;
    assign add_d    = in_expire - st_eff;
    assign add_slot = base_eff + add_d[SLOT_W-1:0];
    assign tk_diff  = in_now - st_eff;
    assign tk_last  = (|tk_diff[TIME_W-1:SLOT_W]) ? '1 : tk_diff[SLOT_W-1:0];
    assign tk_slot  = base_reg + idx_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign rd_head  = slot_rdata[2*PTR_W-1:PTR_W];
    assign rd_tail  = slot_rdata[PTR_W-1:0];
    assign id_ptr   = {1'b0, id_reg};

    always_comb
    begin
        slot_we     = 1'b0;
        slot_waddr  = tk_slot;
        slot_wdata  = {EMPTY, EMPTY};
        next_we     = 1'b0;
        next_waddr  = id_reg;
        next_wdata  = EMPTY;
        prev_we     = 1'b0;
        prev_waddr  = id_reg;
        prev_wdata  = rd_tail;
        eslot_we    = 1'b0;
        eslot_waddr = id_reg;
        eslot_wdata = sslot_reg;
        res_push    = 1'b0;
        res         = '{status: status_reg, valid: 1'b0, id: '0, last: 1'b1};
        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
            end
            S_ADD_WR1:
            begin
                slot_we    = 1'b1;
                slot_waddr = sslot_reg;
                slot_wdata = {(rd_tail >= ITEMS_PTR) ? id_ptr : rd_head, id_ptr};
                next_we    = 1'b1;
                prev_we    = 1'b1;
                eslot_we   = 1'b1;
            end
            S_ADD_WR2:
            begin
                next_we    = (tail_reg < ITEMS_PTR);
                next_waddr = tail_reg[ID_W-1:0];
                next_wdata = id_ptr;
            end
            S_RM_WR:
            begin
                slot_we    = 1'b1;
                slot_waddr = sslot_reg;
                slot_wdata = {(p_reg >= ITEMS_PTR) ? n_reg : rd_head,
                              (n_reg >= ITEMS_PTR) ? p_reg : rd_tail};
                next_we    = (p_reg < ITEMS_PTR);
                next_waddr = p_reg[ID_W-1:0];
                next_wdata = n_reg;
                prev_we    = (n_reg < ITEMS_PTR);
                prev_waddr = n_reg[ID_W-1:0];
                prev_wdata = p_reg;
            end
            S_TK_HEAD:
            begin
                slot_we = 1'b1;
            end
            S_TK_ITEM:
            begin
                res_push = pend_valid_reg && out_free;
                res = '{status: ST_OK, valid: 1'b1, id: pend_id_reg, last: 1'b0};
            end
            S_FINAL:
            begin
                res_push = out_free;
                res = '{status: status_reg, valid: pend_valid_reg,
                        id: pend_valid_reg ? pend_id_reg : '0, last: 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  slot_raddr = add_slot;
            S_RM_RD: slot_raddr = eslot_rdata;
            default: slot_raddr = tk_slot;
        endcase
        next_raddr = (state_reg == S_IDLE) ? in_id : cur_reg[ID_W-1:0];
    end

    twtq_ram #(.WIDTH(2*PTR_W), .DEPTH(SLOTS)) u_slot_ram (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    twtq_ram #(.WIDTH(PTR_W), .DEPTH(ITEMS)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(next_raddr), .rdata(next_rdata)
    );

    twtq_ram #(.WIDTH(PTR_W), .DEPTH(ITEMS)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(in_id), .rdata(prev_rdata)
    );

    twtq_ram #(.WIDTH(SLOT_W), .DEPTH(ITEMS)) u_eslot_ram (
        .clk(clk), .we(eslot_we), .waddr(eslot_waddr), .wdata(eslot_wdata),
        .raddr(in_id), .rdata(eslot_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            start_reg      <= '0;
            base_reg       <= '0;
            linked_reg     <= '0;
            id_reg         <= '0;
            sslot_reg      <= '0;
            tail_reg       <= '0;
            p_reg          <= '0;
            n_reg          <= '0;
            cur_reg        <= '0;
            idx_reg        <= '0;
            last_idx_reg   <= '0;
            now_reg        <= '0;
            status_reg     <= ST_OK;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SLOT_W'(SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        id_reg         <= in_id;
                        pend_valid_reg <= 1'b0;
                        status_reg     <= ST_OK;
                        state_reg      <= S_FINAL;
                        unique case (in_op)
                            OP_ADD:
                            begin
                                if (st_unset)
                                begin
                                    start_reg <= in_now;
                                    base_reg  <= '0;
                                end
                                if (in_now < st_eff)
                                begin
                                    status_reg <= ST_BEFORE;
                                end
                                else if (in_expire < in_now)
                                begin
                                    status_reg <= ST_PAST;
                                end
                                else if (|add_d[TIME_W-1:SLOT_W])
                                begin
                                    status_reg <= ST_BEYOND;
                                end
                                else if (!linked_reg[in_id])
                                begin
                                    sslot_reg <= add_slot;
                                    state_reg <= S_ADD_WR1;
                                end
                            end
                            OP_TICK:
                            begin
                                if (st_unset)
                                begin
                                    start_reg <= in_now;
                                    base_reg  <= '0;
                                end
                                if (in_now < st_eff)
                                begin
                                    status_reg <= ST_BEFORE;
                                end
                                else
                                begin
                                    idx_reg      <= '0;
                                    last_idx_reg <= tk_last;
                                    now_reg      <= in_now;
                                    state_reg    <= S_TK_SLOT;
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (linked_reg[in_id])
                                begin
                                    state_reg <= S_RM_RD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_ADD_WR1:
                begin
                    tail_reg           <= rd_tail;
                    linked_reg[id_reg] <= 1'b1;
                    state_reg          <= S_ADD_WR2;
                end
                S_ADD_WR2:
                begin
                    state_reg <= S_FINAL;
                end
                S_RM_RD:
                begin
                    p_reg     <= prev_rdata;
                    n_reg     <= next_rdata;
                    sslot_reg <= eslot_rdata;
                    state_reg <= S_RM_WR;
                end
                S_RM_WR:
                begin
                    linked_reg[id_reg] <= 1'b0;
                    state_reg          <= S_FINAL;
                end
                S_TK_SLOT:
                begin
                    state_reg <= S_TK_HEAD;
                end
                S_TK_HEAD:
                begin
                    cur_reg <= rd_head;
                    if (rd_head < ITEMS_PTR)
                    begin
                        state_reg <= S_TK_ITEM;
                    end
                    else if (idx_reg == last_idx_reg)
                    begin
                        state_reg <= S_TK_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_TK_SLOT;
                    end
                end
                S_TK_ITEM:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        pend_valid_reg                  <= 1'b1;
                        pend_id_reg                     <= cur_reg[ID_W-1:0];
                        linked_reg[cur_reg[ID_W-1:0]]   <= 1'b0;
                        state_reg                       <= S_TK_NEXT;
                    end
                end
                S_TK_NEXT:
                begin
                    cur_reg <= next_rdata;
                    if (next_rdata < ITEMS_PTR)
                    begin
                        state_reg <= S_TK_ITEM;
                    end
                    else if (idx_reg == last_idx_reg)
                    begin
                        state_reg <= S_TK_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_TK_SLOT;
                    end
                end
                S_TK_DONE:
                begin
                    start_reg <= now_reg;
                    base_reg  <= base_reg + last_idx_reg;
                    state_reg <= S_FINAL;
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> out_free)
        else $error("result pushed while the output register is full");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("input ready during the slot clearing pass");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.last) |=> (state_reg == S_IDLE))
        else $error("final result not followed by idle");

    a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TK_ITEM) |-> (cur_reg < ITEMS_PTR))
        else $error("drain walk on an empty pointer");

endmodule

// ===== sv/timing_wheel_timeout_queue_top.sv =====
// Single-level timing wheel of 1024 slots, each a FIFO list of up to 32 item ids.
// After reset the block clears every slot of the slot memory and accepts no
// transaction until then. An add that links an item passes two write states, and a
// remove of a linked item a read and a write state, before the final state hands the
// result to the output register; other adds and removes, and a no-op, go straight to
// that final state. A tick drains each slot from the base up to the current time and
// walks each list link in turn; the slot and next-pointer memories each give
// one registered read per cycle. Items are taken one at a time.
module timing_wheel_timeout_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // item_id[4:0], expire_time[36:5], now[68:37]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // expired_id[4:0]
    output logic [2:0]  m_axis_tuser,   // status[1:0], expired_valid[2]
    output logic        m_axis_tlast
);
    import twtq_pkg::*;

    logic out_valid_reg;
    res_t out_res_reg;
    logic out_free;
    logic res_push;
    res_t res;

    assign out_free = !out_valid_reg || m_axis_tready;

    twtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (op_t'(s_axis_tuser)),
        .in_id     (s_axis_tdata[ID_W-1:0]),
        .in_expire (s_axis_tdata[36:5]),
        .in_now    (s_axis_tdata[68:37]),
        .out_free  (out_free),
        .res_push  (res_push),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
            out_res_reg   <= res;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg.id};
    assign m_axis_tuser  = {out_res_reg.valid, out_res_reg.status};
    assign m_axis_tlast  = out_res_reg.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import twtq_pkg::*;

    typedef struct {
        op_t     op;
        id_t     id;
        time_t   exp_t;
        time_t   now_t;
        bit      typed;
        status_t st;
    } wheel_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    timing_wheel_timeout_queue_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the wheel.
    time_t wh_start;
    slot_t wh_base;
    ptr_t  wh_head [SLOTS];
    ptr_t  wh_tail [SLOTS];
    ptr_t  wh_next [ITEMS];
    ptr_t  wh_prev [ITEMS];
    slot_t wh_slot [ITEMS];
    bit    wh_linked [ITEMS];

    res_t       expired_q[$];
    wheel_cmd_t dir_tab[$];
    int         errors;
    int         idle_cycles;
    int         send_idle_pct;
    int         stall_pct;
    bit         typed_on;
    status_t    typed_st;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report(input string what, input int got, input int want);
    begin
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    end
    endtask

    function automatic res_t mk_res(status_t st, logic v, id_t id, logic lst);
        res_t r;
        r.status = st;
        r.valid  = v;
        r.id     = id;
        r.last   = lst;
        return r;
    endfunction

    task automatic wheel_predict(input op_t op, input id_t id, input time_t ex, input time_t nw,
                                 ref res_t outq[$]);
        time_t d;
        int    n;
        int    k;
        slot_t s;
        ptr_t  cur;
        ptr_t  nx;
        ptr_t  p;
    begin
        k = 0;
        if (op == OP_ADD || op == OP_TICK)
        begin
            if (wh_start == 0)
            begin
                wh_start = nw;
                wh_base  = '0;
            end
        end
        if ((op == OP_ADD || op == OP_TICK) && nw < wh_start)
            outq.push_back(mk_res(ST_BEFORE, 1'b0, '0, 1'b1));
        else if (op == OP_ADD)
        begin
            d = ex - wh_start;
            if (ex < nw)
                outq.push_back(mk_res(ST_PAST, 1'b0, '0, 1'b1));
            else if (d >= SLOTS)
                outq.push_back(mk_res(ST_BEYOND, 1'b0, '0, 1'b1));
            else
            begin
                if (!wh_linked[id])
                begin
                    s = slot_t'(wh_base + d);
                    p = wh_tail[s];
                    wh_next[id] = EMPTY;
                    wh_prev[id] = p;
                    if (p == EMPTY)
                        wh_head[s] = ptr_t'(id);
                    else
                        wh_next[p[ID_W-1:0]] = ptr_t'(id);
                    wh_tail[s] = ptr_t'(id);
                    wh_slot[id] = s;
                    wh_linked[id] = 1'b1;
                end
                outq.push_back(mk_res(ST_OK, 1'b0, '0, 1'b1));
            end
        end
        else if (op == OP_TICK)
        begin
            n = ((nw - wh_start) >= SLOTS) ? SLOTS : int'(nw - wh_start) + 1;
            for (int i = 0; i < n; i++)
            begin
                s = slot_t'(wh_base + i);
                cur = wh_head[s];
                while (cur != EMPTY && cur < ITEMS_PTR && k < ITEMS)
                begin
                    nx = wh_next[cur[ID_W-1:0]];
                    outq.push_back(mk_res(ST_OK, 1'b1, cur[ID_W-1:0], 1'b0));
                    k++;
                    wh_next[cur[ID_W-1:0]] = EMPTY;
                    wh_prev[cur[ID_W-1:0]] = EMPTY;
                    wh_linked[cur[ID_W-1:0]] = 1'b0;
                    cur = nx;
                end
                wh_head[s] = EMPTY;
                wh_tail[s] = EMPTY;
            end
            wh_start = nw;
            wh_base  = slot_t'(wh_base + n - 1);
            if (k == 0)
                outq.push_back(mk_res(ST_OK, 1'b0, '0, 1'b1));
            else
                outq[outq.size()-1].last = 1'b1;
        end
        else
        begin
            if (op == OP_REMOVE && wh_linked[id])
            begin
                s  = wh_slot[id];
                p  = wh_prev[id];
                nx = wh_next[id];
                if (p == EMPTY || p >= ITEMS_PTR)
                    wh_head[s] = nx;
                else
                    wh_next[p[ID_W-1:0]] = nx;
                if (nx == EMPTY || nx >= ITEMS_PTR)
                    wh_tail[s] = p;
                else
                    wh_prev[nx[ID_W-1:0]] = p;
                wh_next[id] = EMPTY;
                wh_prev[id] = EMPTY;
                wh_linked[id] = 1'b0;
            end
            outq.push_back(mk_res(ST_OK, 1'b0, '0, 1'b1));
        end
    end
    endtask

    // Input and output monitors, plus the watchdog.
    always @(posedge clk)
    begin
        res_t got[$];
        res_t want;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                got = {};
                wheel_predict(op_t'(s_axis_tuser), s_axis_tdata[4:0], s_axis_tdata[36:5],
                              s_axis_tdata[68:37], got);
                if (typed_on)
                    got = '{mk_res(typed_st, 1'b0, '0, 1'b1)};
                foreach (got[i])
                    expired_q.push_back(got[i]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                if (expired_q.size() == 0)
                    report("unexpected transaction", m_axis_tdata[4:0], 0);
                else
                begin
                    want = expired_q.pop_front();
                    if (m_axis_tuser[1:0] != want.status)
                        report("status", m_axis_tuser[1:0], want.status);
                    if (m_axis_tuser[2] != want.valid)
                        report("expired_valid", m_axis_tuser[2], want.valid);
                    if (m_axis_tdata[4:0] != want.id)
                        report("expired_id", m_axis_tdata[4:0], want.id);
                    if (m_axis_tlast != want.last)
                        report("last", m_axis_tlast, want.last);
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= 20000)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send(input wheel_cmd_t c);
    begin
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {3'b0, c.now_t, c.exp_t, c.id};
        typed_on      <= c.typed;
        typed_st      <= c.st;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    end
    endtask

    function automatic wheel_cmd_t cmd(op_t op, id_t id, time_t ex, time_t nw);
        wheel_cmd_t c;
        c.op    = op;
        c.id    = id;
        c.exp_t = ex;
        c.now_t = nw;
        c.typed = 1'b0;
        c.st    = ST_OK;
        return c;
    endfunction

    function automatic wheel_cmd_t random_cmd();
        wheel_cmd_t c;
        time_t      nw;
        int         pick;
    begin
        pick = $urandom_range(99);
        nw = (wh_start == 0) ? time_t'(1000) : wh_start + $urandom_range(0, 3);
        if (pick < 45)
        begin
            c = cmd(OP_ADD, id_t'($urandom_range(0, 31)), nw + $urandom_range(0, 30), nw);
            if ($urandom_range(9) == 0)
                c.exp_t = nw - 1;
            else if ($urandom_range(9) == 0)
                c.exp_t = wh_start + SLOTS + $urandom_range(0, 3) - 1;
        end
        else if (pick < 75)
        begin
            c = cmd(OP_TICK, id_t'($urandom_range(0, 31)), $urandom,
                    nw + $urandom_range(0, 1));
            if ($urandom_range(29) == 0)
                c.now_t = nw + 2000;
        end
        else if (pick < 90)
            c = cmd(OP_REMOVE, id_t'($urandom_range(0, 31)), $urandom, $urandom);
        else
        begin
            c = cmd(OP_NOP, id_t'($urandom_range(0, 31)), $urandom, $urandom);
            case ($urandom_range(2))
                0: c.op = OP_ADD;
                1: c.op = OP_REMOVE;
                default: c.op = OP_NOP;
            endcase
        end
        return c;
    end
    endfunction

    initial
    begin
        wheel_cmd_t c;
        int         stall_tab [4];
        int         idle_tab [4];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        typed_on      = 1'b0;
        typed_st      = ST_OK;
        errors        = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        wh_start      = '0;
        wh_base       = '0;
        foreach (wh_head[i])
        begin
            wh_head[i] = EMPTY;
            wh_tail[i] = EMPTY;
        end
        foreach (wh_linked[i])
        begin
            wh_linked[i] = 1'b0;
            wh_next[i]   = '0;
            wh_prev[i]   = '0;
            wh_slot[i]   = '0;
        end
        dir_tab = '{
            '{OP_TICK,   5'd0,  32'd0,    32'd0,    1'b1, ST_OK},
            '{OP_ADD,    5'd0,  32'd0,    32'd0,    1'b1, ST_OK},
            '{OP_REMOVE, 5'd0,  32'd0,    32'd0,    1'b1, ST_OK},
            '{OP_NOP,    5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK},
            '{OP_ADD,    5'd1,  32'd1000, 32'd100,  1'b1, ST_OK},
            '{OP_ADD,    5'd2,  32'd1123, 32'd100,  1'b1, ST_OK},
            '{OP_ADD,    5'd3,  32'd1124, 32'd100,  1'b1, ST_BEYOND},
            '{OP_ADD,    5'd4,  32'd99,   32'd100,  1'b1, ST_PAST},
            '{OP_ADD,    5'd5,  32'd200,  32'd50,   1'b1, ST_BEFORE},
            '{OP_TICK,   5'd0,  32'd0,    32'd50,   1'b1, ST_BEFORE},
            '{OP_ADD,    5'd1,  32'd300,  32'd100,  1'b1, ST_OK},
            '{OP_ADD,    5'd6,  32'd100,  32'd100,  1'b1, ST_OK},
            '{OP_ADD,    5'd7,  32'd100,  32'd100,  1'b1, ST_OK},
            '{OP_ADD,    5'd8,  32'd101,  32'd100,  1'b1, ST_OK},
            '{OP_TICK,   5'd0,  32'd0,    32'd101,  1'b0, ST_OK},
            '{OP_REMOVE, 5'd2,  32'd0,    32'd0,    1'b1, ST_OK},
            '{OP_REMOVE, 5'd9,  32'd0,    32'd0,    1'b1, ST_OK},
            '{OP_ADD,    5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_BEYOND},
            '{OP_ADD,    5'd10, 32'd500,  32'd101,  1'b1, ST_OK},
            '{OP_TICK,   5'd0,  32'd0,    32'd5101, 1'b0, ST_OK},
            '{OP_ADD,    5'd31, 32'd6124, 32'd5101, 1'b1, ST_OK},
            '{OP_ADD,    5'd30, 32'd6124, 32'd5101, 1'b1, ST_OK},
            '{OP_ADD,    5'd29, 32'd5101, 32'd5101, 1'b1, ST_OK},
            '{OP_TICK,   5'd0,  32'd0,    32'd6124, 1'b0, ST_OK}
        };
        idle_tab  = '{0, 86, 0, 38};
        stall_tab = '{0, 0, 86, 38};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tab[i])
            send(dir_tab[i]);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_tab[ph];
            stall_pct     = stall_tab[ph];
            for (int i = 0; i < 88; i++)
            begin
                if (ph == 1 && i == 40)
                begin
                    s_axis_tvalid <= 1'b0;
                    typed_on      <= 1'b0;
                    @(posedge clk);
                    while (expired_q.size() != 0)
                        @(posedge clk);
                end
                c = random_cmd();
                c.typed = 1'b0;
                send(c);
            end
        end
        s_axis_tvalid <= 1'b0;
        typed_on      <= 1'b0;
        @(posedge clk);
        while (expired_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
